[rtl/evad_pkg.sv]
// Shared types, constants and state encodings for the energy voice activity detector.
// Every other file of the block refers to this package by scoped names.
package evad_pkg;

   // Frame geometry.
   localparam int FRAME_LEN = 512;
   localparam int POS_W     = $clog2(FRAME_LEN);

   // Field and state widths.
   localparam int SAMPLE_W   = 16;
   localparam int SQUARE_W   = 31;
   localparam int FE_W       = 40;
   localparam int CE_W       = 44;
   localparam int LEVEL_W    = 15;
   localparam int SIL_W      = 20;
   localparam int CAL_W      = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int EXP_W      = 6;
   localparam int FRAC_W     = 16;
   localparam int ROUND_W    = 4;
   localparam int NUMER_W    = 17;
   localparam int RECIP_W    = 18;

   // Frame-end queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   // Constants of the level arithmetic.
   localparam logic [24:0]          LN_SCALE     = 25'd29072700;
   localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 15'd32767;
   localparam logic [RECIP_W-1:0]   RECIP_100    = 18'd167773;
   localparam int                   RECIP_SHIFT  = 24;
   localparam logic [NUMER_W-1:0]   CREEP_BIAS   = 17'd40050;
   localparam logic [LEVEL_W:0]     CREEP_OFFSET = 16'd400;
   localparam logic [CAL_W-1:0]     FRAMES_SAT   = 5'd17;
   localparam logic [CAL_W-1:0]     CAL_MAX      = 5'd16;
   localparam logic [CAL_W-1:0]     CAL_MIN      = 5'd1;

   // Register reset values.
   localparam logic [LEVEL_W-1:0] SPEECH_MARGIN_RST = 15'd3200;
   localparam logic [SIL_W-1:0]   SILENCE_LIMIT_RST = 20'd32000;
   localparam logic [CAL_W-1:0]   CALIB_FRAMES_RST  = 5'd10;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEECH_MARGIN = 2'd0,
      CSR_SILENCE_LIMIT = 2'd1,
      CSR_CALIB_FRAMES  = 2'd2
   } evad_csr_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] speech_margin;
      logic [SIL_W-1:0]   silence_limit;
      logic [CAL_W-1:0]   calibration_frames;
   } evad_cfg_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } evad_q_status_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] level;
   } evad_log_result_type;

   typedef enum logic [2:0] {
      LG_IDLE,
      LG_NORM,
      LG_SQUARE,
      LG_FOLD,
      LG_SCALE,
      LG_ROUND,
      LG_DONE
   } evad_log_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_WAIT_FRAME,
      BK_START_CAL,
      BK_WAIT_CAL,
      BK_TRACK_A,
      BK_TRACK_B,
      BK_TRACK_C,
      BK_TRACK_D,
      BK_RESULT
   } evad_back_state_type;

endpackage

[rtl/evad_front.sv]
// Front of the detector: takes sample beats, squares them and sums each frame.
// Pushes the finished frame energy into the frame queue; uses evad_pkg.
module evad_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [evad_pkg::SAMPLE_W-1:0] req_sample,
   input  evad_pkg::evad_q_status_type          q_status,
   output logic                                 push,
   output logic [evad_pkg::FE_W-1:0]            push_energy
);

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_last_ff, s1_last_in;
   logic [evad_pkg::SQUARE_W-1:0]   square_ff, square_in;
   logic [evad_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic [evad_pkg::FE_W-1:0]       energy_ff, energy_in;
   logic signed [31:0]              square_s;
   logic [evad_pkg::FE_W:0]         sum;
   logic [evad_pkg::FE_W-1:0]       sum_sat;
   logic                            hold;
   logic                            accept;
   logic                            fire;

   // The square stage holds a frame's last sample while the queue is full.
   assign hold      = s1_valid_ff & s1_last_ff & q_status.full;
   assign req_stall = hold;
   assign accept    = req_valid & ~hold;
   assign fire      = s1_valid_ff & ~hold;

   // Square of the incoming sample; it never exceeds 2^30.
   assign square_s  = req_sample * req_sample;
   assign square_in = square_s[evad_pkg::SQUARE_W-1:0];

   // Saturating accumulation of the registered square.
   assign sum     = {1'b0, energy_ff} + (evad_pkg::FE_W + 1)'(square_ff);
   assign sum_sat = sum[evad_pkg::FE_W] ? {evad_pkg::FE_W{1'b1}} : sum[evad_pkg::FE_W-1:0];

   assign push        = fire & s1_last_ff;
   assign push_energy = sum_sat;

   // Position within the frame and the square stage.
   always_comb begin
      s1_valid_in = fire ? 1'b0 : s1_valid_ff;
      s1_last_in  = s1_last_ff;
      pos_in      = pos_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_last_in  = (pos_ff == evad_pkg::POS_W'(evad_pkg::FRAME_LEN - 1));
         pos_in      = s1_last_in ? '0 : pos_ff + 1'b1;
      end
   end

   // The accumulator restarts once a finished frame has been pushed.
   always_comb begin
      energy_in = energy_ff;
      if (fire) begin
         energy_in = s1_last_ff ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         pos_ff      <= '0;
         energy_ff   <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pos_ff      <= pos_in;
         energy_ff   <= energy_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff <= s1_last_in;
      if (accept) begin
         square_ff <= square_in;
      end
   end

endmodule

[rtl/evad_queue.sv]
// Short queue of frame energies between the front and the back.
// Lets either side stall on its own; uses evad_pkg.
module evad_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [evad_pkg::FE_W-1:0]     push_data,
   input  logic                          pop,
   output logic [evad_pkg::FE_W-1:0]     pop_data,
   output evad_pkg::evad_q_status_type   status
);

   logic [evad_pkg::FE_W-1:0]   entry_ff [evad_pkg::QUEUE_DEPTH];
   logic [evad_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [evad_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [evad_pkg::QPTR_W:0]   count_ff, count_in;

   assign pop_data         = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == (evad_pkg::QPTR_W + 1)'(evad_pkg::QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

   // Pointers wrap naturally as the depth is a power of two.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/evad_log.sv]
// Iterative level unit: 10*ln(energy) in 1/64 dB from a 44-bit energy.
// Normalises one bit a cycle, then squares the mantissa sixteen times; uses evad_pkg.
module evad_log (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [evad_pkg::CE_W-1:0]       value,
   output evad_pkg::evad_log_result_type   result
);

   evad_pkg::evad_log_state_type state_ff, state_in;

   logic [evad_pkg::CE_W-1:0]    norm_ff, norm_in;
   logic [evad_pkg::EXP_W-1:0]   k_ff, k_in;
   logic [31:0]                  x_ff, x_in;
   logic [63:0]                  prod_ff, prod_in;
   logic [evad_pkg::FRAC_W-1:0]  frac_ff, frac_in;
   logic [evad_pkg::ROUND_W-1:0] round_ff, round_in;
   logic [evad_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [63:0]                  square_full;
   logic [32:0]                  folded;
   logic [46:0]                  scaled;
   logic [47:0]                  rounded;

   assign square_full = x_ff * x_ff;
   assign folded      = prod_ff[63:31];
   assign scaled      = {k_ff, frac_ff} * evad_pkg::LN_SCALE;
   assign rounded     = {1'b0, prod_ff[46:0]} + 48'h0000_8000_0000;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         evad_pkg::LG_IDLE: begin
            if (start) begin
               state_in = (value == '0) ? evad_pkg::LG_DONE : evad_pkg::LG_NORM;
            end
         end
         evad_pkg::LG_NORM: begin
            if (norm_ff[evad_pkg::CE_W-1]) begin
               state_in = evad_pkg::LG_SQUARE;
            end
         end
         evad_pkg::LG_SQUARE: state_in = evad_pkg::LG_FOLD;
         evad_pkg::LG_FOLD: begin
            state_in = (round_ff == '0) ? evad_pkg::LG_SCALE : evad_pkg::LG_SQUARE;
         end
         evad_pkg::LG_SCALE: state_in = evad_pkg::LG_ROUND;
         evad_pkg::LG_ROUND: state_in = evad_pkg::LG_DONE;
         evad_pkg::LG_DONE:  state_in = evad_pkg::LG_IDLE;
         default:            state_in = evad_pkg::LG_IDLE;
      endcase
   end

   // Datapath updates for each step.
   always_comb begin
      norm_in  = norm_ff;
      k_in     = k_ff;
      x_in     = x_ff;
      prod_in  = prod_ff;
      frac_in  = frac_ff;
      round_in = round_ff;
      level_in = level_ff;
      case (state_ff)
         evad_pkg::LG_IDLE: begin
            if (start) begin
               norm_in  = value;
               k_in     = evad_pkg::EXP_W'(evad_pkg::CE_W - 1);
               frac_in  = '0;
               level_in = '0;
            end
         end
         evad_pkg::LG_NORM: begin
            if (norm_ff[evad_pkg::CE_W-1]) begin
               // The leading one sits at the top: the next 31 bits are the fraction.
               x_in     = norm_ff[evad_pkg::CE_W-1 -: 32];
               round_in = evad_pkg::ROUND_W'(evad_pkg::FRAC_W - 1);
            end else begin
               norm_in = {norm_ff[evad_pkg::CE_W-2:0], 1'b0};
               k_in    = k_ff - 1'b1;
            end
         end
         evad_pkg::LG_SQUARE: begin
            prod_in = square_full;
         end
         evad_pkg::LG_FOLD: begin
            // A square of two or more yields a one bit and is halved.
            if (folded[32]) begin
               x_in    = folded[32:1];
               frac_in = {frac_ff[evad_pkg::FRAC_W-2:0], 1'b1};
            end else begin
               x_in    = folded[31:0];
               frac_in = {frac_ff[evad_pkg::FRAC_W-2:0], 1'b0};
            end
            round_in = round_ff - 1'b1;
         end
         evad_pkg::LG_SCALE: begin
            prod_in = 64'(scaled);
         end
         evad_pkg::LG_ROUND: begin
            if (rounded[47:32] > 16'(evad_pkg::LEVEL_MAX)) begin
               level_in = evad_pkg::LEVEL_MAX;
            end else begin
               level_in = rounded[32 +: evad_pkg::LEVEL_W];
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs.
   always_comb begin
      result.done  = (state_ff == evad_pkg::LG_DONE);
      result.level = level_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= evad_pkg::LG_IDLE;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff  <= norm_in;
      k_ff     <= k_in;
      x_ff     <= x_in;
      prod_ff  <= prod_in;
      frac_ff  <= frac_in;
      level_ff <= level_in;
   end

endmodule

[rtl/evad_back.sv]
// Back of the detector: takes frame energies from the queue, tracks levels, classifies.
// Drives the level unit and the result register; uses evad_pkg.
module evad_back (
   input  logic                                clock,
   input  logic                                reset,
   input  evad_pkg::evad_cfg_type              cfg,
   input  evad_pkg::evad_q_status_type         q_status,
   input  logic [evad_pkg::FE_W-1:0]           pop_data,
   output logic                                pop,
   output logic                                log_start,
   output logic [evad_pkg::CE_W-1:0]           log_value,
   input  evad_pkg::evad_log_result_type       log_result,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_speech,
   output logic                                rsp_stop_request,
   output logic [evad_pkg::LEVEL_W-1:0]        rsp_frame_level,
   output logic [evad_pkg::LEVEL_W-1:0]        rsp_background_level,
   output logic                                rsp_calibrating
);

   evad_pkg::evad_back_state_type state_ff, state_in;

   logic [evad_pkg::FE_W-1:0]             energy_ff, energy_in;
   logic [evad_pkg::CE_W-1:0]             calib_energy_ff, calib_energy_in;
   logic [evad_pkg::CAL_W-1:0]            frames_ff, frames_in;
   logic                                  calib_ff, calib_in;
   logic                                  at_cal_ff, at_cal_in;
   logic [evad_pkg::LEVEL_W-1:0]          now_ff, now_in;
   logic [evad_pkg::LEVEL_W-1:0]          speech_level_ff, speech_level_in;
   logic [evad_pkg::LEVEL_W-1:0]          noise_ff, noise_in;
   logic                                  snap_ff, snap_in;
   logic [evad_pkg::NUMER_W-1:0]          numer_ff, numer_in;
   logic [evad_pkg::NUMER_W+evad_pkg::RECIP_W-1:0] prod_ff, prod_in;
   logic                                  speech_ff, speech_in;
   logic [evad_pkg::SIL_W-1:0]            silent_ff, silent_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_is_speech_ff;
   logic                                  rsp_stop_ff;
   logic [evad_pkg::LEVEL_W-1:0]          rsp_frame_level_ff;
   logic [evad_pkg::LEVEL_W-1:0]          rsp_background_ff;
   logic                                  rsp_calibrating_ff;

   logic [evad_pkg::CAL_W-1:0]            cal;
   logic [evad_pkg::CAL_W-1:0]            frames_next;
   logic [evad_pkg::CE_W:0]               calib_sum;
   logic [evad_pkg::CE_W-1:0]             calib_sat;
   logic [evad_pkg::LEVEL_W:0]            avg_sum;
   logic                                  snap;
   logic [evad_pkg::NUMER_W:0]            numer_wide;
   logic [10:0]                           creep_q;
   logic [evad_pkg::LEVEL_W:0]            creep_sum;
   logic [evad_pkg::LEVEL_W-1:0]          floor_level;
   logic [evad_pkg::SIL_W:0]              silent_sum;
   logic [evad_pkg::SIL_W-1:0]            silent_next;
   logic                                  out_free;
   logic                                  load_rsp;

   // Calibration count limited to its working range.
   always_comb begin
      if (cfg.calibration_frames < evad_pkg::CAL_MIN) begin
         cal = evad_pkg::CAL_MIN;
      end else if (cfg.calibration_frames > evad_pkg::CAL_MAX) begin
         cal = evad_pkg::CAL_MAX;
      end else begin
         cal = cfg.calibration_frames;
      end
   end

   assign frames_next = (frames_ff < evad_pkg::FRAMES_SAT) ? frames_ff + 1'b1 : frames_ff;

   // Saturating joint energy of the calibration frames.
   assign calib_sum = {1'b0, calib_energy_ff} + (evad_pkg::CE_W + 1)'(energy_ff);
   assign calib_sat = calib_sum[evad_pkg::CE_W] ? {evad_pkg::CE_W{1'b1}}
                                                : calib_sum[evad_pkg::CE_W-1:0];

   // Tracking arithmetic: averaging, snap-down test and the creep of 0.01 of the gap.
   assign avg_sum     = {1'b0, speech_level_ff} + {1'b0, now_ff};
   assign snap        = (now_ff < noise_ff) && (now_ff != '0);
   assign numer_wide  = {1'b0, now_ff} + {1'b0, evad_pkg::CREEP_BIAS} - {1'b0, noise_ff};
   assign creep_q     = prod_ff[evad_pkg::RECIP_SHIFT +: 11];
   assign creep_sum   = {1'b0, noise_ff} + 16'(creep_q) - evad_pkg::CREEP_OFFSET;
   assign floor_level = (speech_level_ff < noise_ff) ? noise_ff : speech_level_ff;

   // Saturating silence count after this frame.
   assign silent_sum  = {1'b0, silent_ff} + (evad_pkg::SIL_W + 1)'(evad_pkg::FRAME_LEN);
   assign silent_next = speech_ff ? '0 :
                        (silent_sum[evad_pkg::SIL_W] ? {evad_pkg::SIL_W{1'b1}}
                                                     : silent_sum[evad_pkg::SIL_W-1:0]);

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign load_rsp = (state_ff == evad_pkg::BK_RESULT) & out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         evad_pkg::BK_IDLE: begin
            if (q_status.not_empty) begin
               state_in = evad_pkg::BK_WAIT_FRAME;
            end
         end
         evad_pkg::BK_WAIT_FRAME: begin
            if (log_result.done) begin
               if (!calib_ff) begin
                  state_in = evad_pkg::BK_TRACK_A;
               end else if (at_cal_ff) begin
                  state_in = evad_pkg::BK_START_CAL;
               end else begin
                  state_in = evad_pkg::BK_RESULT;
               end
            end
         end
         evad_pkg::BK_START_CAL: state_in = evad_pkg::BK_WAIT_CAL;
         evad_pkg::BK_WAIT_CAL: begin
            if (log_result.done) begin
               state_in = evad_pkg::BK_RESULT;
            end
         end
         evad_pkg::BK_TRACK_A: state_in = evad_pkg::BK_TRACK_B;
         evad_pkg::BK_TRACK_B: state_in = evad_pkg::BK_TRACK_C;
         evad_pkg::BK_TRACK_C: state_in = evad_pkg::BK_TRACK_D;
         evad_pkg::BK_TRACK_D: state_in = evad_pkg::BK_RESULT;
         evad_pkg::BK_RESULT: begin
            if (out_free) begin
               state_in = evad_pkg::BK_IDLE;
            end
         end
         default: state_in = evad_pkg::BK_IDLE;
      endcase
   end

   // Outputs towards the queue and the level unit.
   always_comb begin
      pop       = 1'b0;
      log_start = 1'b0;
      log_value = {{(evad_pkg::CE_W - evad_pkg::FE_W){1'b0}}, pop_data};
      case (state_ff)
         evad_pkg::BK_IDLE: begin
            pop       = q_status.not_empty;
            log_start = q_status.not_empty;
         end
         evad_pkg::BK_START_CAL: begin
            log_start = 1'b1;
            log_value = calib_energy_ff;
         end
         default: begin
         end
      endcase
   end

   // Datapath updates for each step.
   always_comb begin
      energy_in       = energy_ff;
      calib_energy_in = calib_energy_ff;
      frames_in       = frames_ff;
      calib_in        = calib_ff;
      at_cal_in       = at_cal_ff;
      now_in          = now_ff;
      speech_level_in = speech_level_ff;
      noise_in        = noise_ff;
      snap_in         = snap_ff;
      numer_in        = numer_ff;
      prod_in         = prod_ff;
      speech_in       = speech_ff;
      silent_in       = silent_ff;
      case (state_ff)
         evad_pkg::BK_IDLE: begin
            if (q_status.not_empty) begin
               energy_in = pop_data;
               frames_in = frames_next;
               calib_in  = (frames_next <= cal);
               at_cal_in = (frames_next == cal);
               speech_in = 1'b0;
            end
         end
         evad_pkg::BK_WAIT_FRAME: begin
            if (log_result.done) begin
               now_in = log_result.level;
               if (calib_ff) begin
                  calib_energy_in = calib_sat;
               end
            end
         end
         evad_pkg::BK_WAIT_CAL: begin
            if (log_result.done) begin
               noise_in = log_result.level;
            end
         end
         evad_pkg::BK_TRACK_A: begin
            speech_level_in = avg_sum[evad_pkg::LEVEL_W:1];
            snap_in         = snap;
            numer_in        = numer_wide[evad_pkg::NUMER_W-1:0];
            if (snap) begin
               noise_in = now_ff;
            end
         end
         evad_pkg::BK_TRACK_B: begin
            // Division by one hundred through a reciprocal; exact over this range.
            prod_in = numer_ff * evad_pkg::RECIP_100;
         end
         evad_pkg::BK_TRACK_C: begin
            if (!snap_ff) begin
               noise_in = creep_sum[evad_pkg::LEVEL_W-1:0];
            end
         end
         evad_pkg::BK_TRACK_D: begin
            speech_level_in = floor_level;
            speech_in       = ((floor_level - noise_ff) > cfg.speech_margin);
         end
         evad_pkg::BK_RESULT: begin
            if (out_free) begin
               silent_in = silent_next;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register: a new beat may load as the previous one is taken.
   assign rsp_valid_in = load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= evad_pkg::BK_IDLE;
         calib_energy_ff <= '0;
         frames_ff       <= '0;
         speech_level_ff <= '0;
         noise_ff        <= '0;
         silent_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         calib_energy_ff <= calib_energy_in;
         frames_ff       <= frames_in;
         speech_level_ff <= speech_level_in;
         noise_ff        <= noise_in;
         silent_ff       <= silent_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      calib_ff  <= calib_in;
      at_cal_ff <= at_cal_in;
      now_ff    <= now_in;
      snap_ff   <= snap_in;
      numer_ff  <= numer_in;
      prod_ff   <= prod_in;
      speech_ff <= speech_in;
      if (load_rsp) begin
         rsp_is_speech_ff   <= speech_ff;
         rsp_stop_ff        <= (silent_next >= cfg.silence_limit);
         rsp_frame_level_ff <= now_ff;
         rsp_background_ff  <= noise_ff;
         rsp_calibrating_ff <= calib_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_is_speech        = rsp_is_speech_ff;
   assign rsp_stop_request     = rsp_stop_ff;
   assign rsp_frame_level      = rsp_frame_level_ff;
   assign rsp_background_level = rsp_background_ff;
   assign rsp_calibrating      = rsp_calibrating_ff;

endmodule

[rtl/energy_voice_activity_detector.sv]
// Top level of the energy voice activity detector: register bank and the front, queue,
// level unit and back. Depends on evad_pkg, evad_front, evad_queue, evad_log, evad_back.
//
//   Channel  Direction  Handshake           Beat carries
//   req_     in         req_valid/req_stall  one signed 16-bit sample
//   rsp_     out        rsp_valid/rsp_stall  one frame result, one per FRAME_LEN samples
//   csr_     in         csr_valid/csr_ready  register index and write data
//
// The front takes one sample a cycle while req_stall is low and squares and sums it in a
// two-step pipeline. At a frame end the back's work is set by the iterative level unit
// (normalising shifts of one bit, then sixteen square-and-fold rounds); the last
// calibration frame runs the unit twice. A two-entry queue holds finished frames, so
// req_stall rises only when it is full at a frame's last sample. Reset is synchronous
// and acts on the control state and register bank, not on every data register; csr_ready is always high.
module energy_voice_activity_detector (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [evad_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_is_speech,
   output logic                                   rsp_stop_request,
   output logic [evad_pkg::LEVEL_W-1:0]           rsp_frame_level,
   output logic [evad_pkg::LEVEL_W-1:0]           rsp_background_level,
   output logic                                   rsp_calibrating,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [evad_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [evad_pkg::CSR_DATA_W-1:0]        csr_data
);

   evad_pkg::evad_cfg_type         cfg_ff, cfg_in;
   evad_pkg::evad_q_status_type    q_status;
   evad_pkg::evad_log_result_type  log_result;
   logic                           push;
   logic [evad_pkg::FE_W-1:0]      push_energy;
   logic                           pop;
   logic [evad_pkg::FE_W-1:0]      pop_data;
   logic                           log_start;
   logic [evad_pkg::CE_W-1:0]      log_value;

   assign csr_ready = 1'b1;

   // Register writes; an index beyond the list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            evad_pkg::CSR_SPEECH_MARGIN: cfg_in.speech_margin = csr_data[evad_pkg::LEVEL_W-1:0];
            evad_pkg::CSR_SILENCE_LIMIT: cfg_in.silence_limit = csr_data[evad_pkg::SIL_W-1:0];
            evad_pkg::CSR_CALIB_FRAMES: begin
               cfg_in.calibration_frames = csr_data[evad_pkg::CAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speech_margin      <= evad_pkg::SPEECH_MARGIN_RST;
         cfg_ff.silence_limit      <= evad_pkg::SILENCE_LIMIT_RST;
         cfg_ff.calibration_frames <= evad_pkg::CALIB_FRAMES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   evad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_sample  (req_sample),
      .q_status    (q_status),
      .push        (push),
      .push_energy (push_energy)
   );

   evad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_energy),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   evad_log u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .value  (log_value),
      .result (log_result)
   );

   evad_back u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_status             (q_status),
      .pop_data             (pop_data),
      .pop                  (pop),
      .log_start            (log_start),
      .log_value            (log_value),
      .log_result           (log_result),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_is_speech        (rsp_is_speech),
      .rsp_stop_request     (rsp_stop_request),
      .rsp_frame_level      (rsp_frame_level),
      .rsp_background_level (rsp_background_level),
      .rsp_calibrating      (rsp_calibrating)
   );

endmodule

[rtl/evad_checker.sv]
// Port-level checks on the energy voice activity detector, bound to its top level.
// Depends on evad_pkg for widths only.
module evad_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic signed [evad_pkg::SAMPLE_W-1:0] req_sample,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_is_speech,
   input logic                                 rsp_stop_request,
   input logic [evad_pkg::LEVEL_W-1:0]         rsp_frame_level,
   input logic [evad_pkg::LEVEL_W-1:0]         rsp_background_level,
   input logic                                 rsp_calibrating,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [evad_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [evad_pkg::CSR_DATA_W-1:0]      csr_data
);

   // A stalled result beat stays and keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid &&
         $stable({rsp_is_speech, rsp_stop_request, rsp_frame_level,
                  rsp_background_level, rsp_calibrating}))
      else $error("stalled result beat changed or was dropped");

   // A calibration frame is never classified as speech.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibrating |-> !rsp_is_speech)
      else $error("calibration frame reported as speech");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat present straight after reset");

   // Reset leaves the sample side open.
   assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("sample side stalled straight after reset");

endmodule

bind energy_voice_activity_detector evad_checker u_evad_checker (.*);
